[src/bzc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bzc_pkg
// Shared types and constants for the back-EMF zero-crossing commutator.
// ----------------------------------------------------------------------------
package bzc_pkg;

    // request from the comparator side
    typedef struct packed {
        logic sample_u;
        logic sample_v;
        logic sample_w;
    } t_bzc_in;

    // one result per tick
    typedef struct packed {
        logic [1:0]  result_code;
        logic        speed_update;
        logic [15:0] delay_value;
        logic        commutate;
        logic [2:0]  phase_code;
        logic        stall_res;
    } t_bzc_out;

    typedef enum logic [1:0] {
        MODE_DETECT = 2'd0,
        MODE_PRE    = 2'd1,
        MODE_COMMUT = 2'd2
    } t_bzc_mode;

    localparam logic [1:0] RES_UNSETTLED = 2'd0;
    localparam logic [1:0] RES_DETECT    = 2'd1;
    localparam logic [1:0] RES_COMMUT    = 2'd2;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_STALL_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRE_EDGES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_EDGES = 2'd2;

    localparam int CFG_DATA_W = 16;
    localparam int EDGE_W     = 4;

    localparam logic [15:0]       STALL_THR_RST = 16'd10000;
    localparam logic [EDGE_W-1:0] PRE_EDGES_RST = 4'd4;
    localparam logic [EDGE_W-1:0] RUN_EDGES_RST = 4'd12;

endpackage
`default_nettype wire

[src/bemf_zero_cross_commutator.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bemf_zero_cross_commutator
// Debounces three back-EMF comparator levels, measures phase U high time at each falling edge and
// fires commutations once the thirty-degree delay has passed.
// ----------------------------------------------------------------------------
// a result is registered in the output register, or in the skid entry if held
// throughput: one request per cycle unless stalled; per-tick work is one pass of logic
//   from the state registers to the result register, divide by six as a reciprocal multiply
// a two-entry output stage (result register plus skid) keeps requests flowing
//   while a result waits; o_stall rises only when the skid entry is occupied
// reset: synchronous, active low; clears state except output data, loads register defaults
module bemf_zero_cross_commutator #(
    parameter int HISTORY_LEN = 8,
    parameter int TIME_WIDTH  = 16
) (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    i_valid,
    output logic                                   o_stall,
    input  bzc_pkg::t_bzc_in                       i_data,
    output logic                                   o_valid,
    input  wire                                    i_stall,
    output bzc_pkg::t_bzc_out                      o_data,
    input  wire                                    i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire  [bzc_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  wire  [bzc_pkg::CFG_DATA_W-1:0]         i_cfg_data
);
    import bzc_pkg::*;

    localparam int TW    = TIME_WIDTH;
    localparam int CMP_W = (TIME_WIDTH > 16) ? TIME_WIDTH : 16;
    // ceil(2^TW / 3): exact floor(y / 3) for any y below 2^(TW-1)
    localparam logic [63:0]   RECIP64 = ((64'd1 << TIME_WIDTH) + 64'd2) / 64'd3;
    localparam logic [TW-1:0] RECIP   = RECIP64[TW-1:0];

    // configuration
    logic [15:0]       r_stall_thr;
    logic [EDGE_W-1:0] r_pre_edges;
    logic [EDGE_W-1:0] r_run_edges;

    // tick state
    logic [HISTORY_LEN-1:0] r_hist [3];
    logic [HISTORY_LEN-1:0] n_hist [3];
    logic [2:0]        r_levels,  n_levels;
    logic              r_prev_u,  n_prev_u;
    logic [TW-1:0]     r_high,    n_high;
    logic [TW-1:0]     r_idle,    n_idle;
    logic [TW-1:0]     r_delay,   n_delay;
    logic [EDGE_W-1:0] r_edges,   n_edges;
    t_bzc_mode         r_mode,    n_mode;
    logic [TW-1:0]     r_wait,    n_wait;
    logic [2:0]        r_last,    n_last;
    logic              r_stall_f, n_stall_f;

    // output stage
    logic      r_out_valid;
    t_bzc_out  r_out;
    logic      r_skid_valid;
    t_bzc_out  r_skid;

    logic          w_accept;
    logic          w_take;
    t_bzc_out      w_res;
    logic [TW-1:0] w_high_inc;
    logic [TW-2:0] w_half;
    logic [2*TW-1:0] w_prod;
    logic [TW-1:0] w_div6;
    logic [2:0]    w_samples;

    function automatic logic [TW-1:0] sat_inc(input logic [TW-1:0] v);
        sat_inc = (&v) ? v : v + TW'(1);
    endfunction

    assign w_accept    = i_valid && !o_stall;
    assign w_take      = r_out_valid && !i_stall;
    assign o_stall     = r_skid_valid;
    assign o_valid     = r_out_valid;
    assign o_data      = r_out;
    assign o_cfg_ready = 1'b1;

    assign w_samples  = {i_data.sample_w, i_data.sample_v, i_data.sample_u};
    assign w_high_inc = sat_inc(r_high);
    // x / 6 as (x >> 1) / 3 by reciprocal multiply
    assign w_half     = w_high_inc[TW-1:1];
    assign w_prod     = (2*TW)'(w_half) * (2*TW)'(RECIP);
    assign w_div6     = w_prod[2*TW-1:TW];

    always_comb begin
        logic           settled;
        logic           falling;
        logic           run_hit;
        logic [1:0]     code;
        logic           fire;
        logic [CMP_W-1:0] delay_ext;
        n_levels  = r_levels;
        n_prev_u  = r_prev_u;
        n_high    = w_high_inc;
        n_idle    = r_idle;
        n_delay   = r_delay;
        n_edges   = r_edges;
        n_mode    = r_mode;
        n_wait    = r_wait;
        n_last    = r_last;
        n_stall_f = r_stall_f;
        settled   = 1'b1;
        falling   = 1'b0;
        run_hit   = 1'b0;
        code      = RES_UNSETTLED;
        fire      = 1'b0;

        // phases checked in order, stopping at the first unsettled one
        for (int p = 0; p < 3; p++) begin
            n_hist[p] = {r_hist[p][HISTORY_LEN-2:0], w_samples[p]};
            if (settled) begin
                if (&n_hist[p]) begin
                    n_levels[p] = 1'b1;
                end else if (~|n_hist[p]) begin
                    n_levels[p] = 1'b0;
                end else begin
                    n_idle  = sat_inc(n_idle);
                    settled = 1'b0;
                end
            end
        end

        if (settled) begin
            if (n_levels[0] != r_prev_u) begin
                n_prev_u = n_levels[0];
                n_high   = '0;
                n_idle   = '0;
                if (!n_levels[0]) begin
                    falling = 1'b1;
                    n_delay = w_div6;
                    if (r_edges >= r_pre_edges && r_edges < r_run_edges) begin
                        n_mode  = MODE_PRE;
                        n_edges = r_edges + EDGE_W'(1);
                    end else if (r_edges >= r_run_edges) begin
                        n_edges = r_run_edges;
                        n_mode  = MODE_COMMUT;
                        run_hit = 1'b1;
                    end else begin
                        n_edges = r_edges + EDGE_W'(1);
                    end
                end
            end else begin
                n_idle = sat_inc(r_idle);
                if (CMP_W'(n_idle) > CMP_W'(r_stall_thr)) begin
                    n_stall_f = 1'b1;
                end
            end

            if (r_mode == MODE_DETECT) begin
                code = RES_DETECT;
            end else if (r_mode == MODE_PRE) begin
                code = run_hit ? RES_COMMUT : RES_DETECT;
            end else begin
                if (r_last != n_levels) begin
                    n_wait = sat_inc(r_wait);
                end
                if (n_wait > n_delay) begin
                    n_wait = '0;
                    fire   = 1'b1;
                    n_last = n_levels;
                end
                code = RES_COMMUT;
            end
        end

        delay_ext          = CMP_W'(n_delay);
        w_res.result_code  = code;
        w_res.speed_update = falling && (r_mode != MODE_DETECT);
        w_res.delay_value  = delay_ext[15:0];
        w_res.commutate    = fire;
        w_res.phase_code   = n_levels;
        w_res.stall_res    = n_stall_f;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stall_thr <= STALL_THR_RST;
            r_pre_edges <= PRE_EDGES_RST;
            r_run_edges <= RUN_EDGES_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_STALL_THR: r_stall_thr <= i_cfg_data[15:0];
                CFG_PRE_EDGES: r_pre_edges <= i_cfg_data[EDGE_W-1:0];
                CFG_RUN_EDGES: r_run_edges <= i_cfg_data[EDGE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < 3; p++) begin
                r_hist[p] <= '0;
            end
            r_levels  <= '0;
            r_prev_u  <= 1'b0;
            r_high    <= '0;
            r_idle    <= '0;
            r_delay   <= '0;
            r_edges   <= '0;
            r_mode    <= MODE_DETECT;
            r_wait    <= '0;
            r_last    <= '0;
            r_stall_f <= 1'b0;
        end else if (w_accept) begin
            for (int p = 0; p < 3; p++) begin
                r_hist[p] <= n_hist[p];
            end
            r_levels  <= n_levels;
            r_prev_u  <= n_prev_u;
            r_high    <= n_high;
            r_idle    <= n_idle;
            r_delay   <= n_delay;
            r_edges   <= n_edges;
            r_mode    <= n_mode;
            r_wait    <= n_wait;
            r_last    <= n_last;
            r_stall_f <= n_stall_f;
        end
    end

    // result register with skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_accept) begin
            if (!r_out_valid || w_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_take) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            if (!r_out_valid || w_take) begin
                r_out <= w_res;
            end else begin
                r_skid <= w_res;
            end
        end else if (w_take && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

endmodule
`default_nettype wire
